/* hw/rtl/bsfn_pkg.sv */
// shared types and codes for the bitmap store with find-next search
package bsfn_pkg;

	localparam int DEF_WORD_COUNT = 64;
	localparam int WORD_BITS      = 64;
	localparam int BIT_SEL_W      = 6;
	localparam int FIELD_WORDS    = 64;

	typedef logic [2:0] func_t;

	localparam func_t FUNC_SET       = 3'd0;
	localparam func_t FUNC_CLR       = 3'd1;
	localparam func_t FUNC_TEST      = 3'd2;
	localparam func_t FUNC_FIND_ONE  = 3'd3;
	localparam func_t FUNC_FIND_ZERO = 3'd4;
	localparam func_t FUNC_CLR_ALL   = 3'd5;
	localparam func_t FUNC_RESIZE    = 3'd6;

	typedef struct packed {
		func_t       func;
		logic [11:0] bit_index;
		logic [12:0] bit_count;
	} item_t;

	typedef struct packed {
		logic        bit_value;
		logic        found_valid;
		logic [11:0] found_index;
	} result_t;

endpackage

/* hw/rtl/bsfn_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module bsfn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/bitmap_store_find_next.sv */
// top level: bitmap store with set, clear, test, find-next and resize
//
// one beat in, one result beat out. a beat is taken on a clock edge with start
// high and busy low; busy then stays high until the result is shown. the result
// is on result for exactly one cycle with done high and cannot be held off.
// the bitmap lives in one ram of WORD_COUNT words of 64 bits with registered
// read data, so timing follows the ram port. busy drops in the result cycle, so
// the next beat can go in at the edge that takes the result. steps per command:
//   set / clear bit : decode, read, write back; decode only when the word lies
//                     past capacity
//   test            : decode, read; decode only when the word is not in use
//   find next one / zero : decode, then read the words from the start word up to
//                     and including the hit, or all in-use words from the start
//                     word when nothing is found; one word read per cycle, the
//                     scan stops at the first hit
//   clear all       : decode, then sweep the in-use words, one word zeroed per cycle
//   resize          : decode, then zero the dropped words when shrinking
//   unused code     : decode only
// after reset the ram is swept to zero, one word a cycle; busy is high during
// that pass. words outside the in-use range are always kept at zero, so clear
// all and shrink only sweep in-use words.
module bitmap_store_find_next import bsfn_pkg::*; #(
	parameter int WORD_COUNT = DEF_WORD_COUNT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int UW = $clog2(WORD_COUNT + 1);
	localparam int VW = (UW > 8) ? UW : 8;
	localparam logic [VW-1:0] CAP      = VW'(WORD_COUNT);
	localparam logic [VW-1:0] FIELD_WC = VW'(FIELD_WORDS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_RMW,
		S_TEST,
		S_SEARCH
	} state_t;

	// lowest set bit of a byte
	function automatic logic [2:0] ffs8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				r = 3'(i);
			end
		end
		return r;
	endfunction

	state_t          state_q;
	item_t           item_q;
	logic [UW-1:0]   use_q;       // words in use
	logic [UW-1:0]   clr_q;       // sweep pointer
	logic [UW-1:0]   clr_end_q;   // sweep stops here
	logic            boot_q;      // sweep after reset, no result beat
	logic [VW-1:0]   rd_word_q;   // next word the search reads
	logic            first_q;     // next read is the start word
	logic            done_q;
	result_t         result_q;

	// search pipeline: s1 holds ram data, s2 holds per-byte hit info
	logic            valid_s1;
	logic            first_s1;
	logic [VW-1:0]   word_s1;
	logic            valid_s2;
	logic [VW-1:0]   word_s2;
	logic [7:0]      nz_s2;
	logic [7:0][2:0] low_s2;

	// ram port
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// decode of the held beat
	logic [VW-1:0]        word_w;
	logic [VW-1:0]        use_v;
	logic [VW-1:0]        grow_want;
	logic [VW-1:0]        grow_cap;
	logic [VW-1:0]        use_after_set;
	logic [13:0]          rs_round;
	logic [VW-1:0]        rs_words;
	logic [VW-1:0]        rs_cap;
	logic [WORD_BITS-1:0] one_hot;

	// search datapath
	logic [WORD_BITS-1:0] scan_d;
	logic [WORD_BITS-1:0] scan_mask;
	logic [7:0]           byte_nz;
	logic [7:0][2:0]      byte_low;
	logic                 issue;
	logic                 s2_hit;
	logic [2:0]           sel_byte;

	bsfn_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT),
		.AW    (AW)
	) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign word_w    = VW'(item_q.bit_index[11:6]);
	assign use_v     = VW'(use_q);
	assign one_hot   = WORD_BITS'(1) << item_q.bit_index[BIT_SEL_W-1:0];

	// growth on set or clear past the in-use words: floor(3w/2) + 1, capped
	assign grow_want     = word_w + (word_w >> 1) + VW'(1);
	assign grow_cap      = (grow_want > CAP) ? CAP : grow_want;
	assign use_after_set = (word_w >= use_v) ? grow_cap : use_v;

	// resize rounds the bit count up to whole words
	assign rs_round = {1'b0, item_q.bit_count} + 14'd63;
	assign rs_words = VW'(rs_round[13:6]);
	assign rs_cap   = (rs_words > CAP) ? CAP : rs_words;

	// ram access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(word_w);
		ram_wdata = '0;
		ram_raddr = AW'(word_w);
		case (state_q)
			S_CLEAR: begin
				ram_we    = (clr_q < clr_end_q);
				ram_waddr = AW'(clr_q);
			end
			S_RMW: begin
				ram_we    = 1'b1;
				ram_wdata = (item_q.func == FUNC_SET) ? (ram_rdata | one_hot)
				                                      : (ram_rdata & ~one_hot);
			end
			S_SEARCH: begin
				ram_raddr = AW'(rd_word_q);
			end
			default: begin
			end
		endcase
	end

	// first stage of the search: mask the start word, flag bytes with a hit
	always_comb begin
		scan_mask = first_s1 ? ({WORD_BITS{1'b1}} << item_q.bit_index[BIT_SEL_W-1:0])
		                     : {WORD_BITS{1'b1}};
		scan_d    = ((item_q.func == FUNC_FIND_ZERO) ? ~ram_rdata : ram_rdata) & scan_mask;
		for (int b = 0; b < 8; b++) begin
			byte_nz[b]  = |scan_d[8*b +: 8];
			byte_low[b] = ffs8(scan_d[8*b +: 8]);
		end
	end

	assign issue    = (rd_word_q < use_v);
	assign s2_hit   = valid_s2 && (|nz_s2);
	assign sel_byte = ffs8(nz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			item_q    <= '0;
			boot_q    <= 1'b1;
			clr_q     <= '0;
			clr_end_q <= UW'(WORD_COUNT);
			use_q     <= '0;
			rd_word_q <= '0;
			first_q   <= 1'b0;
			valid_s1  <= 1'b0;
			first_s1  <= 1'b0;
			word_s1   <= '0;
			valid_s2  <= 1'b0;
			word_s2   <= '0;
			nz_s2     <= '0;
			low_s2    <= '0;
			done_q    <= 1'b0;
			result_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						item_q  <= item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (item_q.func)
						FUNC_SET, FUNC_CLR: begin
							use_q <= UW'(use_after_set);
							if (word_w < use_after_set) begin
								state_q <= S_RMW;
							end else begin
								done_q   <= 1'b1;
								result_q <= '0;
								state_q  <= S_IDLE;
							end
						end
						FUNC_TEST: begin
							if (word_w < use_v) begin
								state_q <= S_TEST;
							end else begin
								done_q   <= 1'b1;
								result_q <= '0;
								state_q  <= S_IDLE;
							end
						end
						FUNC_FIND_ONE, FUNC_FIND_ZERO: begin
							rd_word_q <= word_w;
							first_q   <= 1'b1;
							valid_s1  <= 1'b0;
							valid_s2  <= 1'b0;
							state_q   <= S_SEARCH;
						end
						FUNC_CLR_ALL: begin
							// words beyond the in-use range are already zero
							clr_q     <= '0;
							clr_end_q <= use_q;
							state_q   <= S_CLEAR;
						end
						FUNC_RESIZE: begin
							// shrink zeroes the dropped words, grow sweeps nothing
							use_q     <= UW'(rs_cap);
							clr_q     <= UW'(rs_cap);
							clr_end_q <= use_q;
							state_q   <= S_CLEAR;
						end
						default: begin
							done_q   <= 1'b1;
							result_q <= '0;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_RMW: begin
					done_q   <= 1'b1;
					result_q <= '0;
					state_q  <= S_IDLE;
				end
				S_TEST: begin
					done_q   <= 1'b1;
					result_q <= '{bit_value: ram_rdata[item_q.bit_index[BIT_SEL_W-1:0]],
					              found_valid: 1'b0, found_index: 12'd0};
					state_q  <= S_IDLE;
				end
				S_CLEAR: begin
					if (clr_q < clr_end_q) begin
						clr_q <= clr_q + UW'(1);
					end else if (boot_q) begin
						boot_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						done_q   <= 1'b1;
						result_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_SEARCH: begin
					valid_s1 <= issue;
					word_s1  <= rd_word_q;
					first_s1 <= first_q;
					if (issue) begin
						rd_word_q <= rd_word_q + VW'(1);
						first_q   <= 1'b0;
					end
					valid_s2 <= valid_s1;
					word_s2  <= word_s1;
					nz_s2    <= byte_nz;
					low_s2   <= byte_low;
					if (s2_hit) begin
						// a hit past the index field counts as not found
						done_q <= 1'b1;
						if (word_s2 < FIELD_WC) begin
							result_q <= '{bit_value: 1'b0, found_valid: 1'b1,
							              found_index: {word_s2[5:0], sel_byte,
							                            low_s2[sel_byte]}};
						end else begin
							result_q <= '0;
						end
						state_q <= S_IDLE;
					end else if (!issue && !valid_s1 && !valid_s2) begin
						done_q   <= 1'b1;
						result_q <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

/* dv/bitmap_store_find_next_tb.sv */
// testbench for the bitmap store: directed and random commands checked against a bitmap shadow
module bitmap_store_find_next_tb import bsfn_pkg::*;;

	// code 7 has no meaning in the block, it must leave everything alone
	localparam func_t FUNC_UNUSED = 3'd7;
	localparam int    CAP_WORDS   = DEF_WORD_COUNT;
	localparam int    PHASES      = 10;
	localparam int    PHASE_BEATS = 200;
	localparam int    REPORT_MAX  = 10;

	// shadow copy of the bitmap, predicts one reply per command and checks replies in order
	class bitmap_shadow;
		logic [63:0] words [CAP_WORDS];
		int unsigned in_use;
		result_t     replies_due [$];
		int unsigned mismatches;

		function new();
			foreach (words[i]) words[i] = '0;
			in_use = 0;
			mismatches = 0;
		endfunction

		// first set (or clear) bit at or after from, within in-use words only
		function bit seek(int unsigned from, bit want_zero, output int unsigned pos);
			int unsigned w;
			logic [63:0] mask, d;
			w = from >> 6;
			mask = ~64'd0 << (from & 63);
			pos = 0;
			while (w < in_use) begin
				d = (want_zero ? ~words[w] : words[w]) & mask;
				if (d != '0) begin
					pos = w * 64;
					while (!d[0]) begin
						d = d >> 1;
						pos++;
					end
					return pos <= 4095;
				end
				mask = '1;
				w++;
			end
			return 1'b0;
		endfunction

		function result_t predict_reply(item_t it);
			result_t     r;
			int unsigned w, n, pos;
			r = '0;
			w = it.bit_index >> 6;
			case (it.func)
				FUNC_SET, FUNC_CLR: begin
					// touching a word w past the in-use range grows the range to floor(3w/2) + 1 words, capped
					if (w >= in_use) begin
						n = ((3 * w) >> 1) + 1;
						in_use = (n > CAP_WORDS) ? CAP_WORDS : n;
					end
					if (w < in_use)
						words[w][it.bit_index[5:0]] = (it.func == FUNC_SET);
				end
				FUNC_TEST: begin
					if (w < in_use)
						r.bit_value = words[w][it.bit_index[5:0]];
				end
				FUNC_FIND_ONE, FUNC_FIND_ZERO: begin
					if (seek(it.bit_index, it.func == FUNC_FIND_ZERO, pos)) begin
						r.found_valid = 1'b1;
						r.found_index = pos[11:0];
					end
				end
				FUNC_CLR_ALL: begin
					foreach (words[i]) words[i] = '0;
				end
				FUNC_RESIZE: begin
					n = (it.bit_count + 63) >> 6;
					if (n > CAP_WORDS)
						n = CAP_WORDS;
					for (int i = n; i < CAP_WORDS; i++)
						words[i] = '0;
					in_use = n;
				end
				default: ;
			endcase
			return r;
		endfunction

		function void take_command(item_t it);
			replies_due.push_back(predict_reply(it));
		endfunction

		function void match_reply(result_t got);
			result_t want;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result beat: %0d %0d %0d",
						got.bit_value, got.found_valid, got.found_index);
				return;
			end
			want = replies_due.pop_front();
			if (got.bit_value !== want.bit_value || got.found_valid !== want.found_valid ||
				got.found_index !== want.found_index) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result mismatch: want bit %0d valid %0d index %0d, got %0d %0d %0d",
						want.bit_value, want.found_valid, want.found_index,
						got.bit_value, got.found_valid, got.found_index);
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	bitmap_shadow shadow = new();

	bitmap_store_find_next DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// safety net: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("bitmap_store_find_next test failed");
		$finish;
	end

	// every result beat lives for one cycle only, so catch it at the closing edge
	always @(posedge clk) begin
		if (arst_n && done)
			shadow.match_reply(result);
	end

	function automatic item_t cmd(func_t f, int unsigned idx, int unsigned cnt);
		item_t it;
		it.func = f;
		it.bit_index = idx[11:0];
		it.bit_count = cnt[12:0];
		return it;
	endfunction

	// idle style of a phase: 0 back to back, 1 random gaps, 2 mostly back to back
	function automatic int unsigned draw_gap(int unsigned style);
		case (style)
			0: return 0;
			1: return $urandom_range(0, 11);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
		endcase
	endfunction

	// random command, with bit positions clustered round a hot spot so that words fill up
	function automatic item_t random_item(int unsigned hot, bit fill);
		item_t       it;
		int unsigned cut [7];
		int unsigned pick, f, sel;
		// cumulative weights in code order: set, clear, test, find one, find zero, clear all,
		// resize, leftover goes to the unused code
		if (fill)
			cut = '{55, 60, 70, 80, 95, 98, 99};
		else
			cut = '{28, 42, 60, 76, 90, 96, 98};
		pick = $urandom_range(0, 99);
		f = 0;
		while (f < 7 && pick >= cut[f])
			f++;
		it.func = func_t'(f);
		if ($urandom_range(0, 99) < 65)
			it.bit_index = 12'(hot + $urandom_range(0, 191));
		else
			it.bit_index = 12'($urandom_range(0, 4095));
		it.bit_count = 13'($urandom_range(0, 8191));
		if (it.func == FUNC_RESIZE) begin
			sel = $urandom_range(0, 9);
			if (sel <= 5)
				it.bit_count = 13'($urandom_range(512, 4096));
			else if (sel <= 7)
				it.bit_count = 13'($urandom_range(0, 4096));
			else if (sel == 8)
				it.bit_count = 13'($urandom_range(0, 64) * 64 + $urandom_range(0, 1));
			else
				it.bit_count = 13'($urandom_range(4097, 8191));
		end
		return it;
	endfunction

	// offer one beat after the idle gap given by gap and hold it until the block takes it
	task automatic issue(item_t it, int unsigned gap);
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		shadow.take_command(it);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (shadow.replies_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		item_t       script [$];
		int unsigned hot;

		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty store, far corners, growth, shrink, clear all and the unused code
		script = '{
			cmd(FUNC_TEST, 0, 0),            // nothing in use yet
			cmd(FUNC_FIND_ONE, 0, 0),        // search with no in-use words
			cmd(FUNC_FIND_ZERO, 0, 8191),
			cmd(FUNC_SET, 0, 0),             // grows to one word
			cmd(FUNC_FIND_ZERO, 0, 0),
			cmd(FUNC_SET, 4095, 0),          // growth capped at capacity
			cmd(FUNC_TEST, 4095, 0),
			cmd(FUNC_FIND_ONE, 1, 0),        // scans the whole store
			cmd(FUNC_FIND_ONE, 4095, 0),
			cmd(FUNC_FIND_ZERO, 4095, 0),    // last bit set, nothing after it
			cmd(FUNC_CLR, 4095, 0),
			cmd(FUNC_FIND_ONE, 1, 0),
			cmd(FUNC_RESIZE, 0, 8191),       // saturates at capacity
			cmd(FUNC_SET, 64, 0),
			cmd(FUNC_RESIZE, 0, 65),         // rounds up to two words
			cmd(FUNC_FIND_ONE, 1, 0),
			cmd(FUNC_RESIZE, 0, 64),         // shrink drops word one
			cmd(FUNC_TEST, 64, 0),
			cmd(FUNC_FIND_ONE, 1, 0),
			cmd(FUNC_CLR, 640, 0),           // clear past the range still grows it
			cmd(FUNC_CLR_ALL, 0, 0),
			cmd(FUNC_FIND_ZERO, 1000, 0),
			cmd(FUNC_RESIZE, 4095, 0),       // empty range
			cmd(FUNC_UNUSED, 4095, 8191),
			cmd(FUNC_RESIZE, 0, 4096)
		};
		foreach (script[i])
			issue(script[i], $urandom_range(0, 3));
		drain();

		// random phases, each with its own hot spot and idle style, drained at the end
		for (int p = 0; p < PHASES; p++) begin
			hot = $urandom_range(0, 4095) & ~32'd63;
			for (int n = 0; n < PHASE_BEATS; n++)
				issue(random_item(hot, p[0]), draw_gap(p % 3));
			drain();
		end

		// longest job is a full scan, leave room for any stray beat to show up
		repeat (100) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
			$display("bitmap_store_find_next test passed");
		else
			$display("bitmap_store_find_next test failed");
		$finish;
	end

endmodule
